// ===== design/siu_pkg.sv =====
package siu_pkg;

  // Width and reset value of the capacity register
  localparam int unsigned CFG_W = 5;
  localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BUILD,
    ST_FLUSH,
    ST_PRIME,
    ST_EMIT,
    ST_OVF
  } siu_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;
    logic build_step;
    logic flush;
    logic emit_load;
    logic ovf_load;
  } siu_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic full;
    logic build_end;
    logic emit_end;
    logic out_free;
  } siu_status_t;

endpackage

// ===== design/siu_if.sv =====
interface siu_in_if #(
  parameter int VALUE_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] lower_bound;
  logic signed [VALUE_BITS-1:0] upper_bound;

  modport source (output valid, output lower_bound, output upper_bound, input ready);
  modport sink   (input valid, input lower_bound, input upper_bound, output ready);
endinterface

interface siu_out_if #(
  parameter int VALUE_BITS = 32,
  parameter int IDX_W      = 4,
  parameter int CNT_W      = 5
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] entry_lower;
  logic signed [VALUE_BITS-1:0] entry_upper;
  logic [IDX_W-1:0]             entry_index;
  logic [CNT_W-1:0]             set_size;
  logic                         overflow_error;
  logic                         last;

  modport source (output valid, output entry_lower, output entry_upper, output entry_index,
                  output set_size, output overflow_error, output last, input ready);
  modport sink   (input valid, input entry_lower, input entry_upper, input entry_index,
                  input set_size, input overflow_error, input last, output ready);
endinterface

interface siu_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [siu_pkg::CFG_W-1:0]   capacity_in_use;

  modport source (output valid, output capacity_in_use, input ready);
  modport sink   (input valid, input capacity_in_use, output ready);
endinterface

// ===== design/siu_ctrl.sv =====
module siu_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  siu_pkg::siu_status_t status,
  output siu_pkg::siu_cmd_t    cmd
);

  siu_pkg::siu_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      siu_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = status.full ? siu_pkg::ST_OVF : siu_pkg::ST_BUILD;
        end
      end
      siu_pkg::ST_BUILD: begin
        if (status.build_end) begin
          state_nxt = siu_pkg::ST_FLUSH;
        end
      end
      siu_pkg::ST_FLUSH: state_nxt = siu_pkg::ST_PRIME;
      siu_pkg::ST_PRIME: state_nxt = siu_pkg::ST_EMIT;
      siu_pkg::ST_EMIT: begin
        if (status.out_free && status.emit_end) begin
          state_nxt = siu_pkg::ST_IDLE;
        end
      end
      siu_pkg::ST_OVF: begin
        if (status.out_free) begin
          state_nxt = siu_pkg::ST_IDLE;
        end
      end
      default: state_nxt = siu_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      siu_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      siu_pkg::ST_BUILD: cmd.build_step = 1'b1;
      siu_pkg::ST_FLUSH: cmd.flush = 1'b1;
      siu_pkg::ST_PRIME: cmd = '0;
      siu_pkg::ST_EMIT:  cmd.emit_load = status.out_free;
      siu_pkg::ST_OVF:   cmd.ovf_load = status.out_free;
      default:           cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= siu_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== design/siu_dpath.sv =====
module siu_dpath #(
  parameter int CAPACITY   = 16,
  parameter int VALUE_BITS = 32,
  parameter int IDX_W      = 4,
  parameter int CNT_W      = 5
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  siu_pkg::siu_cmd_t            cmd,
  output siu_pkg::siu_status_t         status,
  input  logic signed [VALUE_BITS-1:0] in_lower_bound,
  input  logic signed [VALUE_BITS-1:0] in_upper_bound,
  input  logic                         cfg_valid,
  input  logic [siu_pkg::CFG_W-1:0]    cfg_capacity_in_use,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [VALUE_BITS-1:0] out_entry_lower,
  output logic signed [VALUE_BITS-1:0] out_entry_upper,
  output logic [IDX_W-1:0]             out_entry_index,
  output logic [CNT_W-1:0]             out_set_size,
  output logic                         out_overflow_error,
  output logic                         out_last
);

  localparam int CMP_W = (CNT_W > siu_pkg::CFG_W) ? CNT_W : siu_pkg::CFG_W;

  // Interval store
  logic signed [VALUE_BITS-1:0] lower_mem [CAPACITY];
  logic signed [VALUE_BITS-1:0] upper_mem [CAPACITY];
  logic signed [VALUE_BITS-1:0] rd_lo_r, rd_hi_r;

  logic [siu_pkg::CFG_W-1:0] cap_r, cap_nxt;
  logic [CNT_W-1:0]          count_r, count_nxt;
  logic [CNT_W-1:0]          ptr_r, ptr_nxt;
  logic [CNT_W-1:0]          wr_r, wr_nxt;
  logic                      inserted_r, inserted_nxt;
  logic                      cur_valid_r, cur_valid_nxt;
  logic signed [VALUE_BITS-1:0] new_lo_r, new_lo_nxt, new_hi_r, new_hi_nxt;
  logic signed [VALUE_BITS-1:0] cur_lo_r, cur_lo_nxt, cur_hi_r, cur_hi_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic signed [VALUE_BITS-1:0] out_lo_r, out_lo_nxt, out_hi_r, out_hi_nxt;
  logic [IDX_W-1:0]             out_idx_r, out_idx_nxt;
  logic [CNT_W-1:0]             out_size_r, out_size_nxt;
  logic                         out_ovf_r, out_ovf_nxt;
  logic                         out_last_r, out_last_nxt;

  logic                         old_avail, take_new, build_end, emit_end, out_free, step;
  logic signed [VALUE_BITS-1:0] e_lo, e_hi;
  logic                         mem_we;
  logic [IDX_W-1:0]             rd_addr;

  assign old_avail = ptr_r < count_r;
  // New interval goes ahead of the first old entry whose lower bound is not below its own
  assign take_new  = !inserted_r && (!old_avail || !(rd_lo_r < new_lo_r));
  assign build_end = inserted_r && !old_avail;
  assign emit_end  = (ptr_r + CNT_W'(1)) == count_r;
  assign out_free  = !out_valid_r || out_ready;
  assign step      = cmd.build_step && !build_end;
  assign e_lo      = take_new ? new_lo_r : rd_lo_r;
  assign e_hi      = take_new ? new_hi_r : rd_hi_r;

  assign status.full      = (CMP_W'(count_r) >= CMP_W'(cap_r)) ||
                            (count_r == CNT_W'(CAPACITY));
  assign status.build_end = build_end;
  assign status.emit_end  = emit_end;
  assign status.out_free  = out_free;

  always_comb begin
    cap_nxt       = cfg_valid ? cfg_capacity_in_use : cap_r;
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    wr_nxt        = wr_r;
    inserted_nxt  = inserted_r;
    cur_valid_nxt = cur_valid_r;
    new_lo_nxt    = new_lo_r;
    new_hi_nxt    = new_hi_r;
    cur_lo_nxt    = cur_lo_r;
    cur_hi_nxt    = cur_hi_r;
    mem_we        = 1'b0;

    if (cmd.accept) begin
      new_lo_nxt    = in_lower_bound;
      new_hi_nxt    = in_upper_bound;
      ptr_nxt       = '0;
      wr_nxt        = '0;
      inserted_nxt  = 1'b0;
      cur_valid_nxt = 1'b0;
    end

    // One stream element a cycle: open the first entry, merge into the open one, or close it and start anew
    if (step) begin
      if (take_new) begin
        inserted_nxt = 1'b1;
      end else begin
        ptr_nxt = ptr_r + CNT_W'(1);
      end
      if (!cur_valid_r) begin
        cur_valid_nxt = 1'b1;
        cur_lo_nxt    = e_lo;
        cur_hi_nxt    = e_hi;
      end else if (e_lo <= cur_hi_r) begin
        if (e_hi > cur_hi_r) begin
          cur_hi_nxt = e_hi;
        end
      end else begin
        mem_we     = 1'b1;
        wr_nxt     = wr_r + CNT_W'(1);
        cur_lo_nxt = e_lo;
        cur_hi_nxt = e_hi;
      end
    end

    if (cmd.flush) begin
      mem_we    = 1'b1;
      count_nxt = wr_r + CNT_W'(1);
      ptr_nxt   = '0;
    end

    if (cmd.emit_load) begin
      ptr_nxt = ptr_r + CNT_W'(1);
    end
  end

  // Read one ahead so that the read register holds the entry at ptr_r, apart from the read in the flush cycle
  assign rd_addr = (ptr_nxt < CNT_W'(CAPACITY)) ? ptr_nxt[IDX_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      lower_mem[wr_r[IDX_W-1:0]] <= cur_lo_r;
      upper_mem[wr_r[IDX_W-1:0]] <= cur_hi_r;
    end
    rd_lo_r <= lower_mem[rd_addr];
    rd_hi_r <= upper_mem[rd_addr];
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_lo_nxt    = out_lo_r;
    out_hi_nxt    = out_hi_r;
    out_idx_nxt   = out_idx_r;
    out_size_nxt  = out_size_r;
    out_ovf_nxt   = out_ovf_r;
    out_last_nxt  = out_last_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.emit_load) begin
      out_valid_nxt = 1'b1;
      out_lo_nxt    = rd_lo_r;
      out_hi_nxt    = rd_hi_r;
      out_idx_nxt   = ptr_r[IDX_W-1:0];
      out_size_nxt  = count_r;
      out_ovf_nxt   = 1'b0;
      out_last_nxt  = emit_end;
    end else if (cmd.ovf_load) begin
      out_valid_nxt = 1'b1;
      out_lo_nxt    = '0;
      out_hi_nxt    = '0;
      out_idx_nxt   = '0;
      out_size_nxt  = count_r;
      out_ovf_nxt   = 1'b1;
      out_last_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= siu_pkg::CAP_RESET;
      count_r     <= '0;
      ptr_r       <= '0;
      wr_r        <= '0;
      inserted_r  <= 1'b0;
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cap_r       <= cap_nxt;
      count_r     <= count_nxt;
      ptr_r       <= ptr_nxt;
      wr_r        <= wr_nxt;
      inserted_r  <= inserted_nxt;
      cur_valid_r <= cur_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    new_lo_r   <= new_lo_nxt;
    new_hi_r   <= new_hi_nxt;
    cur_lo_r   <= cur_lo_nxt;
    cur_hi_r   <= cur_hi_nxt;
    out_lo_r   <= out_lo_nxt;
    out_hi_r   <= out_hi_nxt;
    out_idx_r  <= out_idx_nxt;
    out_size_r <= out_size_nxt;
    out_ovf_r  <= out_ovf_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_entry_lower    = out_lo_r;
  assign out_entry_upper    = out_hi_r;
  assign out_entry_index    = out_idx_r;
  assign out_set_size       = out_size_r;
  assign out_overflow_error = out_ovf_r;
  assign out_last           = out_last_r;

endmodule

// ===== design/sorted_interval_union.sv =====
// Order: an accepted request passes through the build, flush, prime and emit states;
//   each result is registered out; an overflow result is loaded in the overflow state.
// Throughput: results leave one a cycle while taken; no new request is taken until the
//   build sweep and the emit sweep over the single-write-port interval store are done.
// Reset: synchronous, active low; clears the interval count, sets capacity to 16 and
//   leaves the interval store as it was.
module sorted_interval_union #(
  parameter int CAPACITY   = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  siu_cfg_if.sink    cfg_ch,
  siu_in_if.sink     in_ch,
  siu_out_if.source  out_ch
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  siu_pkg::siu_cmd_t    cmd;
  siu_pkg::siu_status_t status;

  assign cfg_ch.ready = 1'b1;

  siu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  siu_dpath #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS),
    .IDX_W      (IDX_W),
    .CNT_W      (CNT_W)
  ) u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .status              (status),
    .in_lower_bound      (in_ch.lower_bound),
    .in_upper_bound      (in_ch.upper_bound),
    .cfg_valid           (cfg_ch.valid),
    .cfg_capacity_in_use (cfg_ch.capacity_in_use),
    .out_valid           (out_ch.valid),
    .out_ready           (out_ch.ready),
    .out_entry_lower     (out_ch.entry_lower),
    .out_entry_upper     (out_ch.entry_upper),
    .out_entry_index     (out_ch.entry_index),
    .out_set_size        (out_ch.set_size),
    .out_overflow_error  (out_ch.overflow_error),
    .out_last            (out_ch.last)
  );

endmodule

// ===== design/siu_checker.sv =====
module siu_checker #(
  parameter int VALUE_BITS = 32,
  parameter int IDX_W      = 4,
  parameter int CNT_W      = 5
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic signed [VALUE_BITS-1:0] out_entry_lower,
  input logic [IDX_W-1:0]             out_entry_index,
  input logic [CNT_W-1:0]             out_set_size,
  input logic                         out_overflow_error,
  input logic                         out_last
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_entry_lower) &&
                                $stable(out_entry_index) && $stable(out_last))
    else $error("stalled result changed");

  a_ovf_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow_error |-> out_last && out_entry_index == '0)
    else $error("overflow result is not a lone last result");

  a_last_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_overflow_error |->
      out_last == ((CNT_W'(out_entry_index) + CNT_W'(1)) == out_set_size))
    else $error("last flag disagrees with index and set size");

  a_run_advance: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=>
      out_valid && out_entry_index == $past(out_entry_index) + IDX_W'(1))
    else $error("run did not advance to the next entry");

  a_no_request_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("request taken while a run is still being emitted");

endmodule

bind sorted_interval_union siu_checker #(
  .VALUE_BITS (VALUE_BITS),
  .IDX_W      (IDX_W),
  .CNT_W      (CNT_W)
) u_siu_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_entry_lower    (out_ch.entry_lower),
  .out_entry_index    (out_ch.entry_index),
  .out_set_size       (out_ch.set_size),
  .out_overflow_error (out_ch.overflow_error),
  .out_last           (out_ch.last)
);
